FILE: rtl/mphg_pkg.sv
// Shared types and constants for the pack header generator, including the divide-by-300 split.
`default_nettype none

package mphg_pkg;

    localparam int SCR_WIDTH    = 42;
    localparam int RATE_WIDTH   = 22;
    localparam int BASE_WIDTH   = 33;
    localparam int EXT_WIDTH    = 9;
    localparam int VER_WIDTH    = 2;
    localparam int QUAD_BITS    = 2;
    localparam int HALF_WIDTH   = 20;
    localparam int SUM_WIDTH    = HALF_WIDTH + 1;
    localparam int PROD_WIDTH   = 34;
    localparam int QUO_WIDTH    = 15;
    localparam int REM_WIDTH    = 7;
    localparam int WRAP_WIDTH   = 14;
    localparam int RECIP_WIDTH  = 21;
    localparam int RECIP_PROD_WIDTH = SUM_WIDTH + RECIP_WIDTH;
    localparam int DIV_STEPS    = 3;
    localparam int STEP_WIDTH   = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_WIDTH    = 4;
    localparam int S_TDATA_WIDTH = SCR_WIDTH + RATE_WIDTH;
    localparam int M_TDATA_WIDTH = 8;

    // (2^20 - 1) / 75, ceil(2^27 / 75) and the divisor left after dropping the factor 4
    localparam logic [WRAP_WIDTH-1:0]  WRAP_QUO = 14'd13981;
    localparam logic [RECIP_WIDTH-1:0] RECIP_75 = 21'd1789570;
    localparam logic [REM_WIDTH-1:0]   DIV_75   = 7'd75;

    localparam logic [VER_WIDTH-1:0] VER_MPEG2   = 2'd2;
    localparam logic [VER_WIDTH-1:0] VER_RESET   = VER_MPEG2;
    localparam logic [IDX_WIDTH-1:0] LAST_MPEG1  = 4'd11;
    localparam logic [IDX_WIDTH-1:0] LAST_MPEG2  = 4'd13;

    localparam logic [7:0] START_CODE0 = 8'h00;
    localparam logic [7:0] START_CODE1 = 8'h00;
    localparam logic [7:0] START_CODE2 = 8'h01;
    localparam logic [7:0] START_CODE3 = 8'hBA;
    localparam logic [7:0] STUFF_BYTE  = 8'hF8;

    typedef struct packed {
        logic [BASE_WIDTH-1:0] base;
        logic [EXT_WIDTH-1:0]  ext;
        logic [RATE_WIDTH-1:0] rate;
        logic                  mpeg2;
    } mphg_hdr_t;

endpackage

`default_nettype wire

FILE: rtl/mphg_front.sv
// Front end: accepts requests, holds the layout select and splits the reference by 300.
`default_nettype none

module mphg_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mphg_pkg::VER_WIDTH-1:0]      cfg_wr_data,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [mphg_pkg::S_TDATA_WIDTH-1:0]  s_tdata,
    output logic                                     q_valid,
    input  wire logic                                q_ready,
    output mphg_pkg::mphg_hdr_t                      q_data
);
    import mphg_pkg::*;

    logic [VER_WIDTH-1:0]  ver_reg;
    logic                  busy_reg;
    logic [STEP_WIDTH-1:0] step_reg;
    logic [SCR_WIDTH-1:0]  dvd_reg;
    logic [SUM_WIDTH-1:0]  sum_reg;
    logic [PROD_WIDTH-1:0] prod_reg;
    logic [QUO_WIDTH-1:0]  quo_reg;
    logic [RATE_WIDTH-1:0] rate_reg;
    logic                  mpeg2_reg;

    logic                        last_step;
    logic                        advance;
    logic                        accept;
    logic [HALF_WIDTH-1:0]       dvd_hi;
    logic [HALF_WIDTH-1:0]       dvd_lo;
    logic [RECIP_PROD_WIDTH-1:0] recip_prod;
    logic [REM_WIDTH-1:0]        quo_x75;
    logic [REM_WIDTH-1:0]        rem_val;

    assign last_step = busy_reg && (step_reg == STEP_WIDTH'(DIV_STEPS - 1));
    assign advance   = busy_reg && (!last_step || q_ready);
    assign s_tready  = !busy_reg || (last_step && q_ready);
    assign accept    = s_tvalid && s_tready;

    // ticks / 4 = hi * 2^20 + lo, and 2^20 is one more than a multiple of 75
    assign dvd_hi     = dvd_reg[SCR_WIDTH-1 -: HALF_WIDTH];
    assign dvd_lo     = dvd_reg[QUAD_BITS +: HALF_WIDTH];
    assign recip_prod = sum_reg * RECIP_75;
    assign quo_x75    = REM_WIDTH'(quo_reg * DIV_75);
    assign rem_val    = sum_reg[REM_WIDTH-1:0] - quo_x75;

    assign q_valid       = last_step;
    assign q_data.base   = BASE_WIDTH'(prod_reg + PROD_WIDTH'(quo_reg));
    assign q_data.ext    = {rem_val, dvd_reg[QUAD_BITS-1:0]};
    assign q_data.rate   = rate_reg;
    assign q_data.mpeg2  = mpeg2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ver_reg <= VER_RESET;
        end else if (cfg_wr_en) begin
            ver_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (accept) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (advance) begin
            if (last_step) begin
                busy_reg <= 1'b0;
            end
            step_reg <= step_reg + STEP_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            dvd_reg   <= s_tdata[SCR_WIDTH-1:0];
            rate_reg  <= s_tdata[SCR_WIDTH +: RATE_WIDTH];
            mpeg2_reg <= (ver_reg == VER_MPEG2);
        end else if (advance) begin
            sum_reg  <= {1'b0, dvd_hi} + {1'b0, dvd_lo};
            prod_reg <= PROD_WIDTH'(dvd_hi) * PROD_WIDTH'(WRAP_QUO);
            quo_reg  <= recip_prod[RECIP_PROD_WIDTH-1 -: QUO_WIDTH];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mphg_queue.sv
// Two-entry queue between the front end and the byte sequencer.
`default_nettype none

module mphg_queue (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire mphg_pkg::mphg_hdr_t in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output mphg_pkg::mphg_hdr_t out_data
);
    import mphg_pkg::*;

    mphg_hdr_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg;
    logic [QCNT_WIDTH-1:0] cnt_reg;
    logic                  push;
    logic                  pop;

    assign in_ready  = (cnt_reg != QCNT_WIDTH'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_WIDTH'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_WIDTH'(1);
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + QCNT_WIDTH'(1);
                2'b01:   cnt_reg <= cnt_reg - QCNT_WIDTH'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mphg_back.sv
// Back end: walks the header bytes of the queued entry into the output register.
`default_nettype none

module mphg_back (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                q_valid,
    output logic                                     q_ready,
    input  wire mphg_pkg::mphg_hdr_t                 q_data,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [mphg_pkg::M_TDATA_WIDTH-1:0]       m_tdata,
    output logic                                     m_tlast
);
    import mphg_pkg::*;

    logic [IDX_WIDTH-1:0] idx_reg;
    logic [IDX_WIDTH-1:0] idx_next;
    logic                 m_tvalid_reg;
    logic [7:0]           m_tdata_reg;
    logic                 m_tlast_reg;

    logic [IDX_WIDTH-1:0] last_idx;
    logic                 is_last;
    logic                 load;
    logic [7:0]           byte_sel;
    logic [7:0]           byte_m1;
    logic [7:0]           byte_m2;

    assign last_idx = q_data.mpeg2 ? LAST_MPEG2 : LAST_MPEG1;
    assign is_last  = (idx_reg == last_idx);
    assign load     = q_valid && (!m_tvalid_reg || m_tready);
    assign q_ready  = load && is_last;
    assign idx_next = is_last ? '0 : idx_reg + IDX_WIDTH'(1);

    always_comb begin
        unique case (idx_reg)
            4'd4:    byte_m1 = {4'b0010, q_data.base[32:30], 1'b1};
            4'd5:    byte_m1 = q_data.base[29:22];
            4'd6:    byte_m1 = {q_data.base[21:15], 1'b1};
            4'd7:    byte_m1 = q_data.base[14:7];
            4'd8:    byte_m1 = {q_data.base[6:0], 1'b1};
            4'd9:    byte_m1 = {1'b1, q_data.rate[21:15]};
            4'd10:   byte_m1 = q_data.rate[14:7];
            default: byte_m1 = {q_data.rate[6:0], 1'b1};
        endcase
    end

    always_comb begin
        unique case (idx_reg)
            4'd4:    byte_m2 = {2'b01, q_data.base[32:30], 1'b1, q_data.base[29:28]};
            4'd5:    byte_m2 = q_data.base[27:20];
            4'd6:    byte_m2 = {q_data.base[19:15], 1'b1, q_data.base[14:13]};
            4'd7:    byte_m2 = q_data.base[12:5];
            4'd8:    byte_m2 = {q_data.base[4:0], 1'b1, q_data.ext[8:7]};
            4'd9:    byte_m2 = {q_data.ext[6:0], 1'b1};
            4'd10:   byte_m2 = q_data.rate[21:14];
            4'd11:   byte_m2 = q_data.rate[13:6];
            4'd12:   byte_m2 = {q_data.rate[5:0], 2'b11};
            default: byte_m2 = STUFF_BYTE;
        endcase
    end

    always_comb begin
        unique case (idx_reg)
            4'd0:    byte_sel = START_CODE0;
            4'd1:    byte_sel = START_CODE1;
            4'd2:    byte_sel = START_CODE2;
            4'd3:    byte_sel = START_CODE3;
            default: byte_sel = q_data.mpeg2 ? byte_m2 : byte_m1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (load) begin
            idx_reg      <= idx_next;
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= byte_sel;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

FILE: rtl/mpeg_pack_header_generator_unit.sv
// Top level of the MPEG pack header generator: front end, queue and byte sequencer.
//
//   channel   dir  beat contents (low bit first)
//   s_*       in   tdata: scr_ticks[41:0], mplx_rate[63:42]
//   m_*       out  tdata: header_byte[7:0]; tlast: last_byte
//   cfg_*     in   wr_data: mpeg_version[1:0]
//
// In the front end a request goes through the split, the reciprocal multiply and
// the remainder fix-up. Header bytes follow at one beat per cycle while m_tready
// is high, 14 for MPEG-2 and 12 for MPEG-1, so the byte sequencer sets the rate;
// a two-entry queue decouples the sides.
// aresetn is synchronous, active low, and sets the layout to MPEG-2.
// Back pressure on m_* backs up into the queue and then stalls s_tready.
`default_nettype none

module mpeg_pack_header_generator_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mphg_pkg::VER_WIDTH-1:0]      cfg_wr_data,   // mpeg_version
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [mphg_pkg::S_TDATA_WIDTH-1:0]  s_tdata,       // scr_ticks, mplx_rate
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [mphg_pkg::M_TDATA_WIDTH-1:0]       m_tdata,       // header_byte
    output logic                                     m_tlast        // last_byte
);
    import mphg_pkg::*;

    logic      fq_valid;
    logic      fq_ready;
    mphg_hdr_t fq_data;
    logic      qb_valid;
    logic      qb_ready;
    mphg_hdr_t qb_data;

    mphg_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_data      (fq_data)
    );

    mphg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    mphg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_data   (qb_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the MPEG pack header generator with a built-in header predictor.
`timescale 1ns / 100ps

module tb;
    import mphg_pkg::*;

    localparam logic [VER_WIDTH-1:0] VER_MPEG1   = 2'd1;
    localparam logic [VER_WIDTH-1:0] VER_UNUSED0 = 2'd0;
    localparam logic [VER_WIDTH-1:0] VER_UNUSED3 = 2'd3;
    localparam logic [SCR_WIDTH-1:0] SCR_TOP     = 42'd2576980377599;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam int CHUNK_ITEMS  = 40;

    typedef struct packed {
        logic [RATE_WIDTH-1:0] rate;
        logic [SCR_WIDTH-1:0]  ticks;
    } scr_req_t;

    typedef struct packed {
        logic [7:0] hdr;
        logic       last;
    } hdr_beat_t;

    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic [VER_WIDTH-1:0]     cfg_wr_data = '0;
    logic                     s_tvalid    = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata     = '0;
    logic                     m_tvalid;
    logic                     m_tready    = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_tdata;
    logic                     m_tlast;

    scr_req_t             scr_requests[$];
    scr_req_t             corner_reqs[$];
    hdr_beat_t            hdr_bytes_due[$];
    logic [VER_WIDTH-1:0] layout_sel = VER_RESET;
    logic                 s_taken    = 1'b0;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   fails = 0;
    int                   quiet_cycles = 0;

    mpeg_pack_header_generator_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic predict_pack_header(input logic [SCR_WIDTH-1:0] ticks,
                                       input logic [RATE_WIDTH-1:0] rate);
        logic [SCR_WIDTH-1:0]  quot;
        logic [SCR_WIDTH-1:0]  remd;
        logic [BASE_WIDTH-1:0] base;
        logic [EXT_WIDTH-1:0]  ext;
        logic [7:0]            hdr[14];
        int                    n;
        quot = ticks / 42'd300;
        remd = ticks % 42'd300;
        base = quot[BASE_WIDTH-1:0];
        ext  = remd[EXT_WIDTH-1:0];
        hdr[0] = START_CODE0;
        hdr[1] = START_CODE1;
        hdr[2] = START_CODE2;
        hdr[3] = START_CODE3;
        if (layout_sel == VER_MPEG2) begin
            hdr[4]  = {2'b01, base[32:30], 1'b1, base[29:28]};
            hdr[5]  = base[27:20];
            hdr[6]  = {base[19:15], 1'b1, base[14:13]};
            hdr[7]  = base[12:5];
            hdr[8]  = {base[4:0], 1'b1, ext[8:7]};
            hdr[9]  = {ext[6:0], 1'b1};
            hdr[10] = rate[21:14];
            hdr[11] = rate[13:6];
            hdr[12] = {rate[5:0], 2'b11};
            hdr[13] = STUFF_BYTE;
            n = 14;
        end else begin
            hdr[4]  = {4'b0010, base[32:30], 1'b1};
            hdr[5]  = base[29:22];
            hdr[6]  = {base[21:15], 1'b1};
            hdr[7]  = base[14:7];
            hdr[8]  = {base[6:0], 1'b1};
            hdr[9]  = {1'b1, rate[21:15]};
            hdr[10] = rate[14:7];
            hdr[11] = {rate[6:0], 1'b1};
            n = 12;
        end
        for (int i = 0; i < n; i++) begin
            hdr_bytes_due.push_back('{hdr: hdr[i], last: (i == n - 1)});
        end
    endtask

    function automatic scr_req_t rand_request();
        scr_req_t req;
        case ($urandom_range(3))
            0: req.ticks = 42'({$urandom, $urandom});
            1: req.ticks = 42'({$urandom, $urandom}) % (SCR_TOP + 42'd1);
            2: req.ticks = 42'd300 * 42'({$urandom_range(1), $urandom})
                           + 42'($urandom_range(299));
            default: req.ticks = $urandom_range(1) ? SCR_TOP - 42'($urandom_range(999))
                                                   : 42'($urandom_range(999));
        endcase
        req.rate = 22'($urandom);
        return req;
    endfunction

    task automatic wait_drain();
        do begin
            @(posedge aclk);
            #1;
        end while (scr_requests.size() != 0 || s_tvalid || hdr_bytes_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_layout(input logic [VER_WIDTH-1:0] ver);
        wait_drain();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ver;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // drive requests and the random m_tready
    always @(negedge aclk) begin
        scr_req_t nxt;
        logic     load;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            load = scr_requests.size() != 0 && $urandom_range(99) >= send_idle_pct;
            if (load) begin
                nxt = scr_requests.pop_front();
                s_tdata <= nxt;
            end
            s_tvalid <= load;
        end
        m_tready <= aresetn && $urandom_range(99) >= recv_stall_pct;
    end

    // predict, check and watch for hangs
    always @(posedge aclk) begin
        hdr_beat_t want;
        s_taken = 1'b0;
        if (!aresetn) begin
            layout_sel = VER_RESET;
        end else begin
            if (cfg_wr_en)
                layout_sel = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                s_taken = 1'b1;
                predict_pack_header(s_tdata[SCR_WIDTH-1:0],
                                    s_tdata[S_TDATA_WIDTH-1:SCR_WIDTH]);
            end
            if (m_tvalid && m_tready) begin
                if (hdr_bytes_due.size() == 0) begin
                    $error("header_byte: expected none, got %h", m_tdata);
                    fails++;
                end else begin
                    want = hdr_bytes_due.pop_front();
                    if (m_tdata !== want.hdr) begin
                        $error("header_byte: expected %h, got %h", want.hdr, m_tdata);
                        fails++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_byte: expected %b, got %b", want.last, m_tlast);
                        fails++;
                    end
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [VER_WIDTH-1:0] chunk_layout[8];
        int                   idle_mode[4][2];
        chunk_layout = '{VER_MPEG2, VER_MPEG1, VER_UNUSED3, VER_MPEG2,
                         VER_MPEG1, VER_UNUSED0, VER_MPEG2, VER_MPEG1};
        idle_mode = '{'{0, 0}, '{85, 0}, '{0, 85}, '{37, 37}};
        corner_reqs.push_back('{rate: 22'd0,        ticks: 42'd0});
        corner_reqs.push_back('{rate: 22'h3FFFFF,   ticks: SCR_TOP});
        corner_reqs.push_back('{rate: 22'h2AAAAA,   ticks: 42'h3FF_FFFF_FFFF});
        corner_reqs.push_back('{rate: 22'h155555,   ticks: SCR_TOP + 42'd1});
        corner_reqs.push_back('{rate: 22'd1,        ticks: 42'd299});
        corner_reqs.push_back('{rate: 22'h200000,   ticks: 42'd300});
        corner_reqs.push_back('{rate: 22'h0FFFFF,   ticks: 42'h155_5555_5555});
        corner_reqs.push_back('{rate: 22'h300000,   ticks: 42'h2AA_AAAA_AAAA});
        corner_reqs.push_back('{rate: 22'h03FFFF,   ticks: 42'd1288490188800 + 42'd123});
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (corner_reqs[i]) scr_requests.push_back(corner_reqs[i]);
        write_layout(VER_MPEG1);
        foreach (corner_reqs[i]) scr_requests.push_back(corner_reqs[i]);
        write_layout(VER_UNUSED0);
        scr_requests.push_back(corner_reqs[1]);
        scr_requests.push_back(corner_reqs[2]);
        write_layout(VER_UNUSED3);
        scr_requests.push_back(corner_reqs[1]);
        scr_requests.push_back(corner_reqs[6]);

        for (int c = 0; c < 8; c++) begin
            write_layout(chunk_layout[c]);
            send_idle_pct  = idle_mode[c / 2][0];
            recv_stall_pct = idle_mode[c / 2][1];
            repeat (CHUNK_ITEMS) scr_requests.push_back(rand_request());
        end
        wait_drain();

        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: sim.f
rtl/mphg_pkg.sv
rtl/mphg_front.sv
rtl/mphg_queue.sv
rtl/mphg_back.sv
rtl/mpeg_pack_header_generator_unit.sv
dv/tb.sv
